[design/srde_pkg.sv]
// Package for the signed radix digit emitter.
// Holds the microcode format, the program ROM, the reciprocal table and shared constants.
// No dependencies.
package srde_pkg;

  localparam int LEN_W = 5;
  localparam int DIGIT_W = 4;
  localparam int ALPHA_W = 64;
  localparam int CFG_IDX_W = 1;
  localparam int PC_W = 3;
  localparam int RECIP_W = 32;

  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] PLUS_CHAR = 8'h2B;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 1'b1;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_SIGN = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_FIX = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;
  localparam logic [2:0] OP_EMIT = 3'd5;
  localparam logic [2:0] OP_DONE = 3'd6;

  localparam logic [2:0] C_NEXT = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_BAD = 3'd2;
  localparam logic [2:0] C_NOLEN = 3'd3;
  localparam logic [2:0] C_QNZ = 3'd4;
  localparam logic [2:0] C_CNZ = 3'd5;

  localparam logic [PC_W-1:0] PC_START = 3'd0;
  localparam logic [PC_W-1:0] PC_DIV = 3'd2;
  localparam logic [PC_W-1:0] PC_READ = 3'd4;
  localparam logic [PC_W-1:0] PC_DONE = 3'd6;

  typedef struct packed {
    logic [2:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             bad;
  } alpha_info_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      3'd0: w = '{op: OP_LOAD, cond: C_BAD, target: PC_DONE};
      3'd1: w = '{op: OP_SIGN, cond: C_NOLEN, target: PC_DONE};
      3'd2: w = '{op: OP_MUL, cond: C_NEXT, target: PC_START};
      3'd3: w = '{op: OP_FIX, cond: C_QNZ, target: PC_DIV};
      3'd4: w = '{op: OP_READ, cond: C_NEXT, target: PC_START};
      3'd5: w = '{op: OP_EMIT, cond: C_CNZ, target: PC_READ};
      3'd6: w = '{op: OP_DONE, cond: C_ALWAYS, target: PC_START};
      default: w = '{op: OP_DONE, cond: C_ALWAYS, target: PC_START};
    endcase
    return w;
  endfunction

  // floor(2^32 / d); the quotient estimate is low by at most one
  function automatic logic [RECIP_W-1:0] recip_of(input logic [LEN_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      5'd2:  r = 32'h8000_0000;
      5'd3:  r = 32'h5555_5555;
      5'd4:  r = 32'h4000_0000;
      5'd5:  r = 32'h3333_3333;
      5'd6:  r = 32'h2AAA_AAAA;
      5'd7:  r = 32'h2492_4924;
      5'd8:  r = 32'h2000_0000;
      5'd9:  r = 32'h1C71_C71C;
      5'd10: r = 32'h1999_9999;
      5'd11: r = 32'h1745_D174;
      5'd12: r = 32'h1555_5555;
      5'd13: r = 32'h13B1_3B13;
      5'd14: r = 32'h1249_2492;
      5'd15: r = 32'h1111_1111;
      5'd16: r = 32'h1000_0000;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[design/srde_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module srde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/srde_alpha_chk.sv]
// Alphabet checker: finds the alphabet length and flags a bad alphabet.
// Depends on srde_pkg.
module srde_alpha_chk
  import srde_pkg::*;
#(
  parameter int ALPHABET_MAX = 16
) (
  input  logic [ALPHA_W-1:0] alpha_low,
  input  logic [ALPHA_W-1:0] alpha_high,
  output alpha_info_t        info
);

  logic [2*ALPHA_W-1:0]    alpha_all;
  logic [7:0]              b [ALPHABET_MAX];
  logic [ALPHABET_MAX-1:0] run;
  logic [LEN_W-1:0]        len;
  logic                    bad;

  assign alpha_all = {alpha_high, alpha_low};

  always_comb begin
    for (int i = 0; i < ALPHABET_MAX; i++) begin
      b[i] = alpha_all[8*i +: 8];
    end
    run[0] = (b[0] != 8'h00);
    for (int i = 1; i < ALPHABET_MAX; i++) begin
      run[i] = run[i-1] && (b[i] != 8'h00);
    end
    len = '0;
    for (int i = 0; i < ALPHABET_MAX; i++) begin
      if (run[i]) begin
        len = LEN_W'(i + 1);
      end
    end
    bad = !run[0];
    for (int i = 0; i < ALPHABET_MAX; i++) begin
      if (run[i] && (b[i] == MINUS_CHAR || b[i] == PLUS_CHAR)) begin
        bad = 1'b1;
      end
      for (int j = i + 1; j < ALPHABET_MAX; j++) begin
        if (run[j] && (b[i] == b[j])) begin
          bad = 1'b1;
        end
      end
    end
  end

  assign info.len = len;
  assign info.bad = bad;

endmodule

[design/signed_radix_digit_emitter_top.sv]
// Top level of the signed radix digit emitter: microcoded sequencer and datapath.
// Depends on srde_pkg, srde_ram and srde_alpha_chk.
//
// Usage:
//   cfg_* writes the alphabet: index 0 holds bytes 0..7, index 1 bytes 8..15.
//   A zero byte ends the alphabet; its length is the radix. cfg_ready is
//   always high. Write it only while no value is in flight.
//   in_* takes one signed value per request. out_* returns its text one byte
//   per request: '-' for a negative value, then the digits most significant
//   first; out_tlast marks the final byte. A bad alphabet (empty, repeated
//   byte, '+' or '-') yields no bytes; a one-byte alphabet yields only '-' if negative.
//   Sequencing: each digit takes a multiply step, then a correct step, in the
//   reciprocal divide loop, and later a read step to pop the digit RAM and an
//   emit step. A stalled receiver holds the output register and the sequencer
//   at the sign or emit step; nothing is dropped. in_tready rises after the
//   done step that follows the load of the last byte into the output register.
//   Reset clears the alphabet, the sequencer and the output valid.
module signed_radix_digit_emitter_top
  import srde_pkg::*;
#(
  parameter int ALPHABET_MAX = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [CFG_IDX_W-1:0]               cfg_index,
  input  logic [ALPHA_W-1:0]                 cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]   in_tdata,   // [VALUE_WIDTH-1:0] value
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] text_byte
  output logic                               out_tlast   // last_byte
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int ADDR_W = $clog2(VALUE_WIDTH);
  localparam int PROD_W = VALUE_WIDTH + RECIP_W;
  localparam int QD_W = VALUE_WIDTH + LEN_W;

  logic [ALPHA_W-1:0]     alpha_low_r, alpha_high_r;
  logic                   busy_r, busy_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   neg_r, neg_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  alpha_info_t            info;
  ucode_t                 uw;
  logic                   slot_free;
  logic                   advance;
  logic                   take_jump;
  logic                   emit;
  logic [7:0]             emit_byte;
  logic                   emit_last;
  logic [VALUE_WIDTH-1:0] mag_c;
  logic [VALUE_WIDTH-1:0] q0;
  logic [QD_W-1:0]        qd_full;
  logic [VALUE_WIDTH-1:0] r0;
  logic [VALUE_WIDTH-1:0] len_ext;
  logic                   fix;
  logic [VALUE_WIDTH-1:0] r_c;
  logic [VALUE_WIDTH-1:0] q_c;
  logic                   ram_we;
  logic                   ram_re;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [CNT_W-1:0]       cnt_dec;
  logic [DIGIT_W-1:0]     ram_rdata;
  logic [2*ALPHA_W-1:0]   alpha_all;

  srde_alpha_chk #(
    .ALPHABET_MAX(ALPHABET_MAX)
  ) u_alpha_chk (
    .alpha_low (alpha_low_r),
    .alpha_high(alpha_high_r),
    .info      (info)
  );

  srde_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_WIDTH)
  ) u_digit_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(r_c[DIGIT_W-1:0]),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_byte_r;
  assign out_tlast = out_last_r;

  assign alpha_all = {alpha_high_r, alpha_low_r};
  assign uw = ucode_rom(pc_r);
  assign slot_free = !out_valid_r || out_tready;

  assign mag_c = value_r[VALUE_WIDTH-1]
               ? (~value_r) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}
               : value_r;

  assign q0 = prod_r[PROD_W-1:RECIP_W];
  assign qd_full = QD_W'(q0) * QD_W'(len_r);
  assign r0 = rem_r - qd_full[VALUE_WIDTH-1:0];
  assign len_ext = VALUE_WIDTH'(len_r);
  assign fix = (r0 >= len_ext);
  assign r_c = fix ? (r0 - len_ext) : r0;
  assign q_c = q0 + {{(VALUE_WIDTH-1){1'b0}}, fix};

  assign cnt_dec = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
  assign ram_waddr = cnt_r[ADDR_W-1:0];
  assign ram_raddr = cnt_dec[ADDR_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    value_nxt = value_r;
    neg_nxt = neg_r;
    len_nxt = len_r;
    rem_nxt = rem_r;
    prod_nxt = prod_r;
    cnt_nxt = cnt_r;
    advance = 1'b0;
    emit = 1'b0;
    emit_byte = MINUS_CHAR;
    emit_last = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;

    case (uw.cond)
      C_NEXT:   take_jump = 1'b0;
      C_ALWAYS: take_jump = 1'b1;
      C_BAD:    take_jump = info.bad;
      C_NOLEN:  take_jump = (len_r < LEN_W'(2));
      C_QNZ:    take_jump = (q_c != '0);
      C_CNZ:    take_jump = (cnt_r != '0);
      default:  take_jump = 1'b0;
    endcase

    if (busy_r) begin
      case (uw.op)
        OP_LOAD: begin
          len_nxt = info.len;
          neg_nxt = value_r[VALUE_WIDTH-1];
          rem_nxt = mag_c;
          cnt_nxt = '0;
          advance = 1'b1;
        end
        OP_SIGN: begin
          if (!neg_r) begin
            advance = 1'b1;
          end else if (slot_free) begin
            emit = 1'b1;
            emit_byte = MINUS_CHAR;
            emit_last = (len_r < LEN_W'(2));
            advance = 1'b1;
          end
        end
        OP_MUL: begin
          prod_nxt = PROD_W'(rem_r) * PROD_W'(recip_of(len_r));
          advance = 1'b1;
        end
        OP_FIX: begin
          ram_we = 1'b1;
          rem_nxt = q_c;
          cnt_nxt = cnt_r + {{(CNT_W-1){1'b0}}, 1'b1};
          advance = 1'b1;
        end
        OP_READ: begin
          ram_re = 1'b1;
          cnt_nxt = cnt_dec;
          advance = 1'b1;
        end
        OP_EMIT: begin
          if (slot_free) begin
            emit = 1'b1;
            emit_byte = alpha_all[{ram_rdata, 3'b000} +: 8];
            emit_last = (cnt_r == '0);
            advance = 1'b1;
          end
        end
        OP_DONE: begin
          busy_nxt = 1'b0;
          advance = 1'b1;
        end
        default: begin
          busy_nxt = 1'b0;
          advance = 1'b1;
        end
      endcase
    end

    pc_nxt = pc_r;
    if (advance) begin
      pc_nxt = take_jump ? uw.target : pc_r + PC_W'(1);
    end
    if (!busy_r && in_tvalid) begin
      busy_nxt = 1'b1;
      pc_nxt = PC_START;
      value_nxt = in_tdata[VALUE_WIDTH-1:0];
    end

    out_valid_nxt = out_valid_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt = emit_byte;
      out_last_nxt = emit_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r <= '0;
      alpha_high_r <= '0;
      busy_r <= 1'b0;
      pc_r <= PC_START;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALPHA_LOW:  alpha_low_r <= cfg_data;
          REG_ALPHA_HIGH: alpha_high_r <= cfg_data;
          default: ;
        endcase
      end
      busy_r <= busy_nxt;
      pc_r <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    neg_r <= neg_nxt;
    len_r <= len_nxt;
    rem_r <= rem_nxt;
    prod_r <= prod_nxt;
    cnt_r <= cnt_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> busy_r)
    else $error("byte emitted while sequencer idle");

  a_start_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (busy_r && pc_r == PC_START))
    else $error("request did not start the program");

  a_div_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (uw.op == OP_MUL || uw.op == OP_FIX)) |-> (len_r >= LEN_W'(2)))
    else $error("divide loop entered without a radix");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && uw.op == OP_FIX) |-> (cnt_r < CNT_W'(VALUE_WIDTH)))
    else $error("digit stack overflow");

  a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && uw.op == OP_EMIT && slot_free && cnt_r == '0) |=> (out_tvalid && out_tlast))
    else $error("final digit not flagged last");
`endif

endmodule
